### rtl/utf8_to_utf16_lossy_decoder_core_defines.svh
// Assertion macros shared by the decoder modules.
`ifndef UTF8_TO_UTF16_LOSSY_DECODER_CORE_DEFINES_SVH
`define UTF8_TO_UTF16_LOSSY_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define U8U16_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define U8U16_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8U16_ASSERT(label, clk, rstn, prop, msg)
`define U8U16_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/u8u16_pkg.sv
package u8u16_pkg;

    // Byte queue between front and back
    localparam int FIFO_DEPTH = 4;
    // Decode window: longest UTF-8 sequence
    localparam int WIN_DEPTH  = 4;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [20:0] BOM_CP       = 21'h00FEFF;

    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] LEAD3_LOW  = 8'hE0;
    localparam logic [7:0] LEAD3_SURR = 8'hED;
    localparam logic [7:0] CONT_A0    = 8'hA0;
    localparam logic [7:0] CONT_9F    = 8'h9F;
    localparam logic [7:0] CONT_90    = 8'h90;
    localparam logic [7:0] CONT_8F    = 8'h8F;

    // Byte class, set when the byte is accepted
    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } u8u16_cls_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } u8u16_in_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        was_replaced;
        logic        out_last;
    } u8u16_out_t;

    // Queue entry: raw byte, end mark and its class
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        u8u16_cls_t cls;
    } u8u16_entry_t;

endpackage

### rtl/u8u16_front.sv
`include "utf8_to_utf16_lossy_decoder_core_defines.svh"

module u8u16_front #(
    parameter int DEPTH = u8u16_pkg::FIFO_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  u8u16_pkg::u8u16_in_t    s_data,
    output logic                    q_valid,
    output u8u16_pkg::u8u16_entry_t q_entry,
    input  logic                    q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8u16_pkg::u8u16_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    u8u16_pkg::u8u16_cls_t cls;

    // Classify the incoming byte
    always_comb begin
        if (!s_data.in_byte[7]) begin
            cls = u8u16_pkg::CLS_ASCII;
        end else if (s_data.in_byte[7:6] == 2'b10) begin
            cls = u8u16_pkg::CLS_CONT;
        end else if (s_data.in_byte >= u8u16_pkg::LEAD2_MIN &&
                     s_data.in_byte <= u8u16_pkg::LEAD2_MAX) begin
            cls = u8u16_pkg::CLS_LEAD2;
        end else if (s_data.in_byte[7:4] == 4'hE) begin
            cls = u8u16_pkg::CLS_LEAD3;
        end else if (s_data.in_byte >= u8u16_pkg::LEAD4_MIN &&
                     s_data.in_byte <= u8u16_pkg::LEAD4_MAX) begin
            cls = u8u16_pkg::CLS_LEAD4;
        end else begin
            cls = u8u16_pkg::CLS_BAD;
        end
    end

    assign s_ready = (count_reg != CNT_W'(DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{data: s_data.in_byte, last: s_data.in_last, cls: cls};
        end
    end

    `U8U16_ASSERT(a_no_pop_empty, aclk, aresetn, q_pop |-> count_reg != '0, "pop from empty queue")
    `U8U16_ASSERT(a_count_range, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `U8U16_ASSERT(a_wr_ptr_range, aclk, aresetn, wr_ptr_reg <= PTR_W'(DEPTH - 1), "write pointer out of range")

endmodule

### rtl/u8u16_back.sv
`include "utf8_to_utf16_lossy_decoder_core_defines.svh"

module u8u16_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    strip_bom,
    input  logic                    q_valid,
    input  u8u16_pkg::u8u16_entry_t q_entry,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output u8u16_pkg::u8u16_out_t   m_data
);

    localparam int WD = u8u16_pkg::WIN_DEPTH;

    // Decode window
    logic [7:0]            win_byte_reg [WD];
    logic [7:0]            win_byte_next [WD];
    u8u16_pkg::u8u16_cls_t win_cls_reg [WD];
    u8u16_pkg::u8u16_cls_t win_cls_next [WD];
    logic [2:0]            count_reg, count_next;
    logic                  final_reg, final_next;
    logic                  at_start_reg, at_start_next;

    // Result register and held low surrogate
    logic                  m_valid_reg, m_valid_next;
    u8u16_pkg::u8u16_out_t m_data_reg, m_data_next;
    logic                  lo_valid_reg, lo_valid_next;
    u8u16_pkg::u8u16_out_t lo_data_reg, lo_data_next;

    // Decision signals
    logic [7:0]  b0, b1, b2, b3;
    logic        c1, c2, c3;
    logic [2:0]  need;
    logic        have_all, dec_ready, ok, bad, is_bom, is_pair, is_end;
    logic [20:0] cp;
    logic [19:0] v;
    logic [2:0]  consume, consume_eff, cnt_after;
    logic        can_issue, fire, final_after, head_free;

    assign b0 = win_byte_reg[0];
    assign b1 = win_byte_reg[1];
    assign b2 = win_byte_reg[2];
    assign b3 = win_byte_reg[3];
    assign c1 = (win_cls_reg[1] == u8u16_pkg::CLS_CONT);
    assign c2 = (win_cls_reg[2] == u8u16_pkg::CLS_CONT);
    assign c3 = (win_cls_reg[3] == u8u16_pkg::CLS_CONT);

    // Sequence length, well-formedness and code point of the window front
    always_comb begin
        need = 3'd1;
        ok   = 1'b0;
        cp   = {13'b0, b0};
        case (win_cls_reg[0])
            u8u16_pkg::CLS_ASCII: begin
                need = 3'd1;
                cp   = {14'b0, b0[6:0]};
            end
            u8u16_pkg::CLS_LEAD2: begin
                need = 3'd2;
                cp   = {10'b0, b0[4:0], b1[5:0]};
            end
            u8u16_pkg::CLS_LEAD3: begin
                need = 3'd3;
                cp   = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
            end
            u8u16_pkg::CLS_LEAD4: begin
                need = 3'd4;
                cp   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            end
            default: begin
                need = 3'd1;
            end
        endcase
        have_all = (count_reg >= need);
        case (win_cls_reg[0])
            u8u16_pkg::CLS_LEAD2: ok = have_all && c1;
            u8u16_pkg::CLS_LEAD3: ok = have_all && c1 && c2 &&
                !(b0 == u8u16_pkg::LEAD3_LOW && b1 < u8u16_pkg::CONT_A0) &&
                !(b0 == u8u16_pkg::LEAD3_SURR && b1 > u8u16_pkg::CONT_9F);
            u8u16_pkg::CLS_LEAD4: ok = have_all && c1 && c2 && c3 &&
                !(b0 == u8u16_pkg::LEAD4_MIN && b1 < u8u16_pkg::CONT_90) &&
                !(b0 == u8u16_pkg::LEAD4_MAX && b1 > u8u16_pkg::CONT_8F);
            default:              ok = 1'b0;
        endcase
    end

    assign dec_ready = (count_reg != '0) && (have_all || final_reg);
    assign bad       = !(ok || win_cls_reg[0] == u8u16_pkg::CLS_ASCII);
    assign consume   = bad ? 3'd1 : need;
    assign is_bom    = at_start_reg && strip_bom && ok &&
                       win_cls_reg[0] == u8u16_pkg::CLS_LEAD3 && cp == u8u16_pkg::BOM_CP;
    assign is_pair   = ok && (cp[20:16] != '0);
    assign is_end    = final_reg && (consume == count_reg);
    assign v         = 20'(cp - u8u16_pkg::SUPP_BASE);

    assign head_free = !m_valid_reg || m_ready;
    assign can_issue = !lo_valid_reg && head_free;
    assign fire      = dec_ready && can_issue;

    // Result staging
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        lo_valid_next = lo_valid_reg;
        lo_data_next  = lo_data_reg;
        if (lo_valid_reg && head_free) begin
            m_valid_next  = 1'b1;
            m_data_next   = lo_data_reg;
            lo_valid_next = 1'b0;
        end else if (fire) begin
            if (is_bom) begin
                // Dropped mark; an empty end marker if it closes the stream
                if (is_end) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{code_unit: '0, unit_valid: 1'b0,
                                     was_replaced: 1'b0, out_last: 1'b1};
                end
            end else if (is_pair) begin
                m_valid_next  = 1'b1;
                m_data_next   = '{code_unit: u8u16_pkg::SURR_HI_BASE | {6'b0, v[19:10]},
                                  unit_valid: 1'b1, was_replaced: 1'b0, out_last: 1'b0};
                lo_valid_next = 1'b1;
                lo_data_next  = '{code_unit: u8u16_pkg::SURR_LO_BASE | {6'b0, v[9:0]},
                                  unit_valid: 1'b1, was_replaced: 1'b0, out_last: is_end};
            end else begin
                m_valid_next = 1'b1;
                m_data_next  = '{code_unit: bad ? u8u16_pkg::REPL_UNIT : cp[15:0],
                                 unit_valid: 1'b1, was_replaced: bad, out_last: is_end};
            end
        end
    end

    // Window shift and refill from the queue
    assign consume_eff = fire ? consume : 3'd0;
    assign cnt_after   = count_reg - consume_eff;
    assign final_after = final_reg && !(fire && is_end);
    assign q_pop       = q_valid && !final_after && (cnt_after != 3'(WD));

    always_comb begin
        for (int i = 0; i < WD; i++) begin
            win_byte_next[i] = win_byte_reg[i];
            win_cls_next[i]  = win_cls_reg[i];
        end
        for (int s = 1; s < WD; s++) begin
            if (consume_eff == 3'(s)) begin
                for (int i = 0; i + s < WD; i++) begin
                    win_byte_next[i] = win_byte_reg[i + s];
                    win_cls_next[i]  = win_cls_reg[i + s];
                end
            end
        end
        if (q_pop) begin
            win_byte_next[cnt_after[1:0]] = q_entry.data;
            win_cls_next[cnt_after[1:0]]  = q_entry.cls;
        end
        count_next    = cnt_after + {2'b0, q_pop};
        final_next    = final_after || (q_pop && q_entry.last);
        at_start_next = at_start_reg;
        if (fire) begin
            at_start_next = is_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            final_reg    <= 1'b0;
            at_start_reg <= 1'b1;
            m_valid_reg  <= 1'b0;
            lo_valid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            final_reg    <= final_next;
            at_start_reg <= at_start_next;
            m_valid_reg  <= m_valid_next;
            lo_valid_reg <= lo_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        lo_data_reg <= lo_data_next;
        for (int i = 0; i < WD; i++) begin
            win_byte_reg[i] <= win_byte_next[i];
            win_cls_reg[i]  <= win_cls_next[i];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `U8U16_ASSERT(a_lo_behind_head, aclk, aresetn, lo_valid_reg |-> m_valid_reg, "low surrogate held without a high one")
    `U8U16_ASSERT(a_win_range, aclk, aresetn, count_reg <= 3'(WD), "window overfilled")
    `U8U16_ASSERT(a_final_nonempty, aclk, aresetn, final_reg |-> count_reg != '0, "end mark in empty window")
    `U8U16_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid_reg && !lo_valid_reg, "result left after reset")

endmodule

### rtl/utf8_to_utf16_lossy_decoder_core.sv
// Channel  Ports                       Payload
// input    s_valid s_ready s_data      u8u16_in_t  (one UTF-8 byte, end mark)
// result   m_valid m_ready m_data      u8u16_out_t (one UTF-16 unit or end marker)
// config   cfg_wr_en cfg_wr_data       strip_bom
//
// While m_ready is high, sustains one byte per cycle: the back end decides
// one sequence per cycle from its four-byte window while no low surrogate
// is held, and the result register moves one unit per cycle; a surrogate
// pair gives two result units for four input bytes. A unit reaches m_valid
// via the queue, window and result register after its last byte is taken.
// Reset is synchronous, active low, and empties the queue, window and result.
// The input queue of FIFO_DEPTH entries keeps accepting while results stall, until full.

module utf8_to_utf16_lossy_decoder_core #(
    parameter int FIFO_DEPTH = u8u16_pkg::FIFO_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  u8u16_pkg::u8u16_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output u8u16_pkg::u8u16_out_t m_data
);

    logic                    strip_bom_reg;
    logic                    q_valid;
    logic                    q_pop;
    u8u16_pkg::u8u16_entry_t q_entry;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_bom_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            strip_bom_reg <= cfg_wr_data;
        end
    end

    u8u16_front #(
        .DEPTH(FIFO_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    u8u16_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .strip_bom (strip_bom_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
